/* rtl/cslq_pkg.sv */
package cslq_pkg;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_JOIN_TAIL = 2'd0;
    localparam logic [1:0] OP_JOIN_POS  = 2'd1;
    localparam logic [1:0] OP_LOOKUP    = 2'd2;
    localparam logic [1:0] OP_LEAVE     = 2'd3;

    // Result kind codes of an output beat.
    localparam logic [1:0] RK_JOIN   = 2'd0;
    localparam logic [1:0] RK_LOOKUP = 2'd1;
    localparam logic [1:0] RK_MOVE   = 2'd2;
    localparam logic [1:0] RK_MISS   = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] member_id;
        logic [3:0]  position;
    } request_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        ok;
        logic [15:0] member;
        logic [3:0]  place;
        logic        is_first;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_JP_CHECK,
        ST_JP_SCAN,
        ST_SEARCH,
        ST_SHIFT,
        ST_CLEAR
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_CNT,
        RD_CNT_NEXT,
        RD_POS,
        RD_HIT_NEXT
    } rd_src_t;

    typedef enum logic [1:0] {
        WA_NONE,
        WA_TAIL,
        WA_POS,
        WA_PREV
    } wr_addr_t;

    typedef enum logic [1:0] {
        WD_ID,
        WD_RDATA,
        WD_ZERO
    } wr_data_t;

    typedef enum logic [1:0] {
        TAIL_KEEP,
        TAIL_INC,
        TAIL_DEC,
        TAIL_LD_RD
    } tail_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_CLR,
        CNT_INC,
        CNT_LD_HIT
    } cnt_op_t;

    typedef enum logic [1:0] {
        POSF_KEEP,
        POSF_POS,
        POSF_TAIL
    } posf_op_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_REFUSE,
        EM_JOIN_TAIL,
        EM_JOIN_POS,
        EM_LOOK_HIT,
        EM_LOOK_MISS,
        EM_LEAVE_MISS,
        EM_MOVE
    } emit_t;

    typedef struct packed {
        logic     load;
        rd_src_t  rd;
        cnt_op_t  cnt;
        wr_addr_t wa;
        wr_data_t wd;
        tail_op_t tail;
        posf_op_t posf;
        emit_t    emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       id_zero;
        logic       pos_bad;
        logic       tail_full;
        logic       tail_zero;
        logic       rd_zero;
        logic       rd_match;
        logic       cnt_zero;
        logic       cnt_full;
        logic       search_end;
        logic       move_last;
    } status_t;

endpackage

/* rtl/cslq_ram.sv */
module cslq_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic                     re,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cslq_ctrl.sv */
module cslq_ctrl
    import cslq_pkg::*;
    (
        input  logic    clk,
        input  logic    rst_n,
        input  logic    start,
        output logic    busy,
        input  status_t st,
        output cmd_t    cmd
    );

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.rd     = RD_NONE;
        cmd.cnt    = CNT_KEEP;
        cmd.wa     = WA_NONE;
        cmd.wd     = WD_ID;
        cmd.tail   = TAIL_KEEP;
        cmd.posf   = POSF_KEEP;
        cmd.emit   = EM_NONE;
        busy       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cmd.cnt    = CNT_CLR;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (st.op) inside
                    OP_JOIN_TAIL:
                    begin
                        if (st.id_zero || st.tail_full)
                        begin
                            cmd.emit = EM_REFUSE;
                        end
                        else
                        begin
                            cmd.wa   = WA_TAIL;
                            cmd.wd   = WD_ID;
                            cmd.tail = TAIL_INC;
                            cmd.emit = EM_JOIN_TAIL;
                        end
                    end
                    OP_JOIN_POS:
                    begin
                        if (st.id_zero || st.pos_bad)
                        begin
                            cmd.emit = EM_REFUSE;
                        end
                        else
                        begin
                            cmd.rd     = RD_POS;
                            state_next = ST_JP_CHECK;
                        end
                    end
                    OP_LOOKUP, OP_LEAVE:
                    begin
                        if (st.id_zero || st.tail_zero)
                        begin
                            cmd.emit = (st.op == OP_LOOKUP) ? EM_LOOK_MISS : EM_LEAVE_MISS;
                        end
                        else
                        begin
                            cmd.rd     = RD_CNT;
                            cmd.cnt    = CNT_INC;
                            state_next = ST_SEARCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_JP_CHECK:
            begin
                if (!st.rd_zero)
                begin
                    if (st.tail_full)
                    begin
                        cmd.emit   = EM_REFUSE;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.posf   = POSF_TAIL;
                        cmd.wa     = WA_TAIL;
                        cmd.wd     = WD_ID;
                        cmd.tail   = TAIL_INC;
                        state_next = ST_JP_SCAN;
                    end
                end
                else
                begin
                    cmd.posf   = POSF_POS;
                    cmd.wa     = WA_POS;
                    cmd.wd     = WD_ID;
                    state_next = ST_JP_SCAN;
                end
            end

            ST_JP_SCAN:
            begin
                if (!st.cnt_zero && st.rd_zero)
                begin
                    cmd.tail = TAIL_LD_RD;
                end
                if (st.cnt_full)
                begin
                    cmd.emit   = EM_JOIN_POS;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd  = RD_CNT;
                    cmd.cnt = CNT_INC;
                end
            end

            ST_SEARCH:
            begin
                if (st.rd_match)
                begin
                    if (st.op == OP_LOOKUP)
                    begin
                        cmd.emit   = EM_LOOK_HIT;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd     = RD_HIT_NEXT;
                        cmd.cnt    = CNT_LD_HIT;
                        state_next = ST_SHIFT;
                    end
                end
                else if (st.search_end)
                begin
                    cmd.emit   = (st.op == OP_LOOKUP) ? EM_LOOK_MISS : EM_LEAVE_MISS;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd  = RD_CNT;
                    cmd.cnt = CNT_INC;
                end
            end

            ST_SHIFT:
            begin
                cmd.wa   = WA_PREV;
                cmd.wd   = WD_RDATA;
                cmd.emit = EM_MOVE;
                if (st.move_last)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    cmd.rd  = RD_CNT_NEXT;
                    cmd.cnt = CNT_INC;
                end
            end

            ST_CLEAR:
            begin
                if (!st.tail_full)
                begin
                    cmd.wa = WA_TAIL;
                    cmd.wd = WD_ZERO;
                end
                cmd.tail   = TAIL_DEC;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/cslq_dp.sv */
module cslq_dp
    import cslq_pkg::*;
    #(
        parameter int SLOTS   = 16,
        parameter int ID_BITS = 16
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  request_t request,
        input  cmd_t     cmd,
        output status_t  st,
        output result_t  result,
        output logic     result_valid
    );

    localparam int IW = $clog2(SLOTS);
    localparam int TW = $clog2(SLOTS + 1);

    logic [1:0]         op_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [3:0]         pos_reg;
    logic [TW-1:0]      cnt_reg;
    logic [TW-1:0]      tail_reg;
    logic [IW-1:0]      posf_reg;
    logic [TW-1:0]      rd_idx_reg;
    logic               rd_vld_reg;
    logic [SLOTS-1:0]   vld_reg;
    result_t            res_reg;
    logic               strobe_reg;

    logic [TW-1:0]      rd_addr;
    logic               rd_en;
    logic               rd_in_range;
    logic [ID_BITS-1:0] ram_q;
    logic [ID_BITS-1:0] rdata;
    logic [TW-1:0]      prev_idx;
    logic [TW-1:0]      cnt_plus;
    logic [TW-1:0]      hit_plus;
    logic               we;
    logic [IW-1:0]      waddr;
    logic [ID_BITS-1:0] wdata;
    result_t            res_next;

    assign cnt_plus = cnt_reg + TW'(1);
    assign hit_plus = rd_idx_reg + TW'(1);
    assign prev_idx = rd_idx_reg - TW'(1);

    // Read address selection; reads beyond the last slot come back as empty.
    always_comb
    begin
        case (cmd.rd)
            RD_CNT:      rd_addr = cnt_reg;
            RD_CNT_NEXT: rd_addr = cnt_plus;
            RD_POS:      rd_addr = TW'(pos_reg);
            RD_HIT_NEXT: rd_addr = hit_plus;
            default:     rd_addr = cnt_reg;
        endcase
    end

    assign rd_en       = (cmd.rd != RD_NONE);
    assign rd_in_range = (rd_addr < TW'(SLOTS));
    assign rdata       = rd_vld_reg ? ram_q : '0;

    always_comb
    begin
        case (cmd.wa)
            WA_TAIL: waddr = IW'(tail_reg);
            WA_POS:  waddr = IW'(pos_reg);
            WA_PREV: waddr = IW'(prev_idx);
            default: waddr = IW'(tail_reg);
        endcase
        case (cmd.wd)
            WD_ID:    wdata = id_reg;
            WD_RDATA: wdata = rdata;
            default:  wdata = '0;
        endcase
    end

    assign we = (cmd.wa != WA_NONE);

    cslq_ram
        #(
            .WIDTH (ID_BITS),
            .DEPTH (SLOTS)
        )
        u_ram
        (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (rd_en),
            .raddr (IW'(rd_addr)),
            .rdata (ram_q)
        );

    // Captured request and index registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= request.operation;
            id_reg  <= ID_BITS'(request.member_id);
            pos_reg <= request.position;
        end
        case (cmd.posf)
            POSF_POS:  posf_reg <= IW'(pos_reg);
            POSF_TAIL: posf_reg <= IW'(tail_reg);
            default:   posf_reg <= posf_reg;
        endcase
        if (rd_en)
        begin
            rd_idx_reg <= rd_addr;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            tail_reg   <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            case (cmd.cnt)
                CNT_CLR:    cnt_reg <= '0;
                CNT_INC:    cnt_reg <= cnt_plus;
                CNT_LD_HIT: cnt_reg <= hit_plus;
                default:    cnt_reg <= cnt_reg;
            endcase
            case (cmd.tail)
                TAIL_INC:   tail_reg <= tail_reg + TW'(1);
                TAIL_DEC:   tail_reg <= tail_reg - TW'(1);
                TAIL_LD_RD: tail_reg <= rd_idx_reg;
                default:    tail_reg <= tail_reg;
            endcase
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= rd_in_range && vld_reg[IW'(rd_addr)];
            end
            strobe_reg <= (cmd.emit != EM_NONE);
        end
    end

    // Result formatting.
    always_comb
    begin
        res_next.result_kind = RK_JOIN;
        res_next.ok          = 1'b0;
        res_next.member      = 16'(id_reg);
        res_next.place       = 4'd0;
        res_next.is_first    = 1'b0;
        res_next.last        = 1'b1;
        case (cmd.emit)
            EM_JOIN_TAIL:
            begin
                res_next.ok       = 1'b1;
                res_next.place    = 4'(tail_reg);
                res_next.is_first = (tail_reg == '0);
            end
            EM_JOIN_POS:
            begin
                res_next.ok       = 1'b1;
                res_next.place    = 4'(posf_reg);
                res_next.is_first = (posf_reg == '0);
            end
            EM_LOOK_HIT:
            begin
                res_next.result_kind = RK_LOOKUP;
                res_next.ok          = 1'b1;
                res_next.place       = 4'(rd_idx_reg);
                res_next.is_first    = (rd_idx_reg == '0);
            end
            EM_LOOK_MISS:
            begin
                res_next.result_kind = RK_LOOKUP;
            end
            EM_LEAVE_MISS:
            begin
                res_next.result_kind = RK_MISS;
            end
            EM_MOVE:
            begin
                res_next.result_kind = RK_MOVE;
                res_next.ok          = 1'b1;
                res_next.member      = 16'(rdata);
                res_next.place       = 4'(prev_idx);
                res_next.is_first    = (prev_idx == '0);
                res_next.last        = st.move_last;
            end
            default:
            begin
                res_next.result_kind = RK_JOIN;
            end
        endcase
    end

    assign st.op         = op_reg;
    assign st.id_zero    = (id_reg == '0);
    assign st.pos_bad    = (32'(pos_reg) >= 32'(SLOTS));
    assign st.tail_full  = (tail_reg >= TW'(SLOTS));
    assign st.tail_zero  = (tail_reg == '0);
    assign st.rd_zero    = (rdata == '0);
    assign st.rd_match   = (rdata == id_reg);
    assign st.cnt_zero   = (cnt_reg == '0);
    assign st.cnt_full   = (cnt_reg >= TW'(SLOTS));
    assign st.search_end = (cnt_reg >= tail_reg);
    assign st.move_last  = (rd_idx_reg >= tail_reg) || (rd_idx_reg >= TW'(SLOTS));

    assign result       = res_reg;
    assign result_valid = strobe_reg;

endmodule

/* rtl/compacting_slot_queue_top.sv */
// Ordered table of member IDs with a tail index, driven by a command channel.
// A request beat (operation, member_id, position) is taken at a rising edge
// where start is high and busy is low; busy stays high until the last result
// of that beat has been formed. Every result beat is shown on result for one
// cycle with result_valid high; the receiver has no means to stall it.
// A join at the tail is decided in the decode state and its result beat is
// registered; a new request is taken only once busy is low again. A join at a
// position reads its slot and then scans the whole table for the highest
// free slot. A lookup scans the occupied slots one per cycle. A leave
// searches up to the member at slot k, gives one move beat per cycle for
// the tail - k later slots, then clears the old tail slot. The scans are
// paced by the single read port of the slot RAM, which delivers one entry
// per cycle.
// Reset clears the tail index and the per-slot valid bits at once, so every
// slot reads as empty straight after reset; no clearing pass is needed.
module compacting_slot_queue_top
    import cslq_pkg::*;
    #(
        parameter int SLOTS   = 16,
        parameter int ID_BITS = 16
    )
    (
        input  logic     clk,
        input  logic     rst_n,
        input  logic     start,
        output logic     busy,
        input  request_t request,
        output result_t  result,
        output logic     result_valid
    );

    // Commands from the sequencer and the flags it branches on.
    cmd_t    cmd;
    status_t st;

    // The sequencer decides per cycle which slot to read, what to write
    // and which result beat to form; it holds no data of its own.
    cslq_ctrl u_ctrl
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (start),
            .busy  (busy),
            .st    (st),
            .cmd   (cmd)
        );

    // The datapath keeps the slot RAM, its valid bits, the tail index, the
    // scan counter and the registered result beat.
    cslq_dp
        #(
            .SLOTS   (SLOTS),
            .ID_BITS (ID_BITS)
        )
        u_dp
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .request      (request),
            .cmd          (cmd),
            .st           (st),
            .result       (result),
            .result_valid (result_valid)
        );

endmodule
